>>> src/cae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types, widths and character codes of the cursor address expander.
// ----------------------------------------------------------------------------
package cae_pkg;

    // width of the line and column values, two's complement, wrapping
    localparam int VALUE_W = 16;
    // the subtract unit must hold 99999 and any value magnitude
    localparam int ACC_W = (VALUE_W > 17) ? VALUE_W : 17;
    localparam int THR_W = 9;

    localparam logic [ACC_W-1:0] DEC_MAX = ACC_W'(99999);

    // ceil(2^(VALUE_W+3) / 10): exact quotient by ten of any VALUE_W-bit magnitude
    localparam logic [VALUE_W:0] DIV10_MUL =
        (VALUE_W+1)'(((64'd1 << (VALUE_W + 3)) / 64'd10) + 64'd1);

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THR  = 8'h33;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_BB   = 8'h42;
    localparam logic [7:0] CH_DD   = 8'h44;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_N    = 8'h6e;
    localparam logic [7:0] CH_R    = 8'h72;

    localparam logic [VALUE_W-1:0] XOR_MASK = VALUE_W'(8'o140);

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_PCT  = 2'd1,
        PH_X    = 2'd2,
        PH_Y    = 2'd3
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_EMIT = 6'b000100,
        S_DEC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_BFIN = 6'b100000
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       bad_template;
        logic       end_of_string;
    } t_result;

    // decimal weight of digit position 0 to 4
    function automatic logic [ACC_W-1:0] pow10(input logic [2:0] pos);
        logic [ACC_W-1:0] w;
        unique case (pos)
            3'd0:    w = ACC_W'(1);
            3'd1:    w = ACC_W'(10);
            3'd2:    w = ACC_W'(100);
            3'd3:    w = ACC_W'(1000);
            3'd4:    w = ACC_W'(10000);
            default: w = ACC_W'(1);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> src/cae_sub_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cae_sub_unit
// Compare and subtract unit: flags a >= b and gives a - b.
// ----------------------------------------------------------------------------
module cae_sub_unit (
    input  wire logic [cae_pkg::ACC_W-1:0] i_a,
    input  wire logic [cae_pkg::ACC_W-1:0] i_b,
    output logic                           o_ge,
    output logic [cae_pkg::ACC_W-1:0]      o_diff
);

    logic [cae_pkg::ACC_W:0] w_sum;

    assign w_sum  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sum[cae_pkg::ACC_W];
    assign o_diff = w_sum[cae_pkg::ACC_W-1:0];

endmodule
`default_nettype wire

>>> src/cae_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cae_out_reg
// Output register of the result channel, loaded while empty or being taken.
// ----------------------------------------------------------------------------
module cae_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cae_pkg::t_result i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output cae_pkg::t_result      o_data,
    input  wire logic             i_stall
);

    logic             r_valid;
    cae_pkg::t_result r_data;

    assign o_ready = ~r_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> src/cursor_address_string_expander_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_address_string_expander_top
// Expands a cursor-motion template into terminal characters, byte by byte.
// ----------------------------------------------------------------------------
// Input channel: one template byte per request, with start and end marks;
// the first byte of a template also carries the line and column values.
// Output channel: zero or more characters (or an empty marker result) per request,
// with the error flag and an end-of-string mark on the last result.
// The block takes one request at a time and holds o_in_stall high until
// all its results are handed to the output register.
// Plain bytes and single-character directives: decode (S_EXEC), then emit (S_EMIT).
// Decimal directives: the subtract unit steps through five digit positions,
// subtracting the power of ten once per unit of the digit (S_DEC).
// %B: the quotient by ten comes from a reciprocal multiply (S_DIV, then S_BFIN).
// Other directives: decode only; a final byte with no character adds an empty result.
// Reset (synchronous, active low) returns to normal text, line first,
// values zero, error clear, output register empty.
// A stall on the output holds the current result and pauses the sequencer.
// ----------------------------------------------------------------------------
module cursor_address_string_expander_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_template_byte,
    input  wire logic       i_starts_template,
    input  wire logic [9:0] i_line_in,
    input  wire logic [9:0] i_column_in,
    input  wire logic       i_ends_template,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_bad_template,
    output logic            o_end_of_string
);

    localparam int W = cae_pkg::VALUE_W;
    localparam int A = cae_pkg::ACC_W;

    cae_pkg::t_state r_state, n_state;
    cae_pkg::t_phase r_phase, n_phase;
    logic [cae_pkg::THR_W-1:0] r_thr, n_thr;
    logic [W-1:0] r_line, n_line;
    logic [W-1:0] r_col, n_col;
    logic r_turn, n_turn;
    logic r_err, n_err;

    logic [7:0] r_byte, n_byte;
    logic r_end, n_end;
    logic [7:0] r_emit_b, n_emit_b;
    logic r_emit_bv, n_emit_bv;
    logic [A-1:0] r_acc, n_acc;
    logic [3:0] r_digit, n_digit;
    logic [2:0] r_pos, n_pos;
    logic [1:0] r_pad, n_pad;
    logic r_started, n_started;
    logic r_neg, n_neg;

    logic [A-1:0] w_sub_a, w_sub_b, w_sub_diff;
    logic w_sub_ge;
    logic w_push, w_out_ready;
    cae_pkg::t_result w_res, w_out;
    logic w_in_acc;

    logic [W-1:0] w_cur, w_mag;
    logic [A-1:0] w_cur_ext, w_sat;
    logic [cae_pkg::THR_W-1:0] w_bdelta;
    logic [W-1:0] w_thr_ext, w_bdelta_ext;
    logic [W-1:0] w_drem, w_dres;
    logic [2*W:0] w_prod;
    logic [W-1:0] w_q, w_q6, w_bres;

    assign w_in_acc  = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != cae_pkg::S_IDLE);

    assign w_cur     = r_turn ? r_line : r_col;
    assign w_mag     = w_cur[W-1] ? (~w_cur + 1'b1) : w_cur;
    assign w_cur_ext = A'(w_cur);
    assign w_sat     = (w_cur_ext > cae_pkg::DEC_MAX) ? cae_pkg::DEC_MAX : w_cur_ext;

    // byte minus '0', nine-bit two's complement
    assign w_bdelta     = cae_pkg::THR_W'(r_byte) - cae_pkg::THR_W'(cae_pkg::CH_ZERO);
    assign w_thr_ext    = {{(W-cae_pkg::THR_W){r_thr[cae_pkg::THR_W-1]}}, r_thr};
    assign w_bdelta_ext = {{(W-cae_pkg::THR_W){w_bdelta[cae_pkg::THR_W-1]}}, w_bdelta};

    // remainder mod 16 takes the sign of the value
    assign w_drem = w_cur[W-1] ? (~W'(w_mag[3:0]) + 1'b1) : W'(w_mag[3:0]);
    assign w_dres = w_cur - {w_drem[W-2:0], 1'b0};

    // 16*(v/10) + v%10 is v + 6*(v/10), quotient truncated toward zero
    assign w_prod = r_acc[W-1:0] * cae_pkg::DIV10_MUL;
    assign w_q    = r_acc[W-1:0];
    assign w_q6   = {w_q[W-3:0], 2'b00} + {w_q[W-2:0], 1'b0};
    assign w_bres = r_neg ? (w_cur - w_q6) : (w_cur + w_q6);

    cae_sub_unit u_sub (
        .i_a    (w_sub_a),
        .i_b    (w_sub_b),
        .o_ge   (w_sub_ge),
        .o_diff (w_sub_diff)
    );

    always_comb begin
        cae_pkg::t_phase ph_v;
        logic err_v;
        logic newerr_v;
        logic emit_v;
        logic dec_v;
        logic div_v;
        logic [7:0] emit_b_v;
        logic show_v;

        n_state   = r_state;
        n_phase   = r_phase;
        n_thr     = r_thr;
        n_line    = r_line;
        n_col     = r_col;
        n_turn    = r_turn;
        n_err     = r_err;
        n_byte    = r_byte;
        n_end     = r_end;
        n_emit_b  = r_emit_b;
        n_emit_bv = r_emit_bv;
        n_acc     = r_acc;
        n_digit   = r_digit;
        n_pos     = r_pos;
        n_pad     = r_pad;
        n_started = r_started;
        n_neg     = r_neg;
        w_sub_a   = '0;
        w_sub_b   = '0;
        w_push    = 1'b0;
        w_res     = '0;
        ph_v      = r_phase;
        err_v     = r_err;
        newerr_v  = 1'b0;
        emit_v    = 1'b0;
        dec_v     = 1'b0;
        div_v     = 1'b0;
        emit_b_v  = 8'h00;
        show_v    = 1'b0;

        unique case (r_state)
            cae_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_byte = i_template_byte;
                    n_end  = i_ends_template;
                    if (i_starts_template) begin
                        n_line  = W'(i_line_in);
                        n_col   = W'(i_column_in);
                        n_turn  = 1'b1;
                        n_err   = 1'b0;
                        n_phase = cae_pkg::PH_TEXT;
                    end
                    n_state = cae_pkg::S_EXEC;
                end
            end
            cae_pkg::S_EXEC: begin
                if (!r_err) begin
                    unique case (r_phase)
                        cae_pkg::PH_TEXT: begin
                            if (r_byte == cae_pkg::CH_PCT) begin
                                ph_v = cae_pkg::PH_PCT;
                            end else begin
                                emit_v   = 1'b1;
                                emit_b_v = r_byte;
                            end
                        end
                        cae_pkg::PH_PCT: begin
                            ph_v = cae_pkg::PH_TEXT;
                            unique case (r_byte)
                                cae_pkg::CH_C: begin
                                    emit_v   = 1'b1;
                                    emit_b_v = w_cur[7:0];
                                    n_turn   = ~r_turn;
                                end
                                cae_pkg::CH_D, cae_pkg::CH_TWO, cae_pkg::CH_THR: begin
                                    n_turn = ~r_turn;
                                    if (!w_cur[W-1]) begin
                                        dec_v     = 1'b1;
                                        n_acc     = w_sat;
                                        n_pos     = 3'd4;
                                        n_digit   = 4'd0;
                                        n_started = 1'b0;
                                        n_pad     = (r_byte == cae_pkg::CH_D)   ? 2'd0 :
                                                    (r_byte == cae_pkg::CH_TWO) ? 2'd2 : 2'd3;
                                    end
                                end
                                cae_pkg::CH_PCT: begin
                                    emit_v   = 1'b1;
                                    emit_b_v = cae_pkg::CH_PCT;
                                end
                                cae_pkg::CH_R: begin
                                    n_turn = ~r_turn;
                                end
                                cae_pkg::CH_I: begin
                                    n_line = r_line + 1'b1;
                                    n_col  = r_col + 1'b1;
                                end
                                cae_pkg::CH_GT: begin
                                    ph_v = cae_pkg::PH_X;
                                end
                                cae_pkg::CH_N: begin
                                    n_line = r_line ^ cae_pkg::XOR_MASK;
                                    n_col  = r_col ^ cae_pkg::XOR_MASK;
                                end
                                cae_pkg::CH_BB: begin
                                    div_v = 1'b1;
                                    n_neg = w_cur[W-1];
                                    n_acc = A'(w_mag);
                                end
                                cae_pkg::CH_DD: begin
                                    if (r_turn) begin
                                        n_line = w_dres;
                                    end else begin
                                        n_col = w_dres;
                                    end
                                end
                                default: begin
                                    err_v    = 1'b1;
                                    newerr_v = 1'b1;
                                end
                            endcase
                        end
                        cae_pkg::PH_X: begin
                            n_thr = w_bdelta;
                            ph_v  = cae_pkg::PH_Y;
                        end
                        cae_pkg::PH_Y: begin
                            ph_v = cae_pkg::PH_TEXT;
                            if ($signed(w_cur) > $signed(w_thr_ext)) begin
                                if (r_turn) begin
                                    n_line = w_cur + w_bdelta_ext;
                                end else begin
                                    n_col = w_cur + w_bdelta_ext;
                                end
                            end
                        end
                        default: begin
                            ph_v = cae_pkg::PH_TEXT;
                        end
                    endcase
                    // template ended inside a directive
                    if (r_end && ph_v != cae_pkg::PH_TEXT && !err_v) begin
                        err_v    = 1'b1;
                        newerr_v = 1'b1;
                    end
                    if (err_v) begin
                        ph_v = cae_pkg::PH_TEXT;
                    end
                end
                if (r_end) begin
                    ph_v = cae_pkg::PH_TEXT;
                end
                n_phase = ph_v;
                n_err   = err_v;

                priority if (emit_v) begin
                    n_emit_b  = emit_b_v;
                    n_emit_bv = 1'b1;
                    n_state   = cae_pkg::S_EMIT;
                end else if (dec_v) begin
                    n_state = cae_pkg::S_DEC;
                end else if (div_v) begin
                    n_state = cae_pkg::S_DIV;
                end else if (r_end || newerr_v) begin
                    n_emit_b  = 8'h00;
                    n_emit_bv = 1'b0;
                    n_state   = cae_pkg::S_EMIT;
                end else begin
                    n_state = cae_pkg::S_IDLE;
                end
            end
            cae_pkg::S_EMIT: begin
                w_push = 1'b1;
                w_res  = '{out_byte: r_emit_b, byte_valid: r_emit_bv,
                           bad_template: r_err, end_of_string: r_end};
                if (w_out_ready) begin
                    n_state = cae_pkg::S_IDLE;
                end
            end
            cae_pkg::S_DEC: begin
                w_sub_a = r_acc;
                w_sub_b = cae_pkg::pow10(r_pos);
                if (w_sub_ge) begin
                    n_acc   = w_sub_diff;
                    n_digit = r_digit + 4'd1;
                end else begin
                    // leading zeros drop unless padding asks for them
                    show_v = r_started || (r_digit != 4'd0) ||
                             (r_pos < {1'b0, r_pad}) || (r_pos == 3'd0);
                    if (show_v) begin
                        w_push = 1'b1;
                        w_res  = '{out_byte: cae_pkg::CH_ZERO + {4'b0000, r_digit},
                                   byte_valid: 1'b1, bad_template: r_err,
                                   end_of_string: r_end && (r_pos == 3'd0)};
                    end
                    if (!show_v || w_out_ready) begin
                        n_started = r_started | show_v;
                        n_digit   = 4'd0;
                        if (r_pos == 3'd0) begin
                            n_state = cae_pkg::S_IDLE;
                        end else begin
                            n_pos = r_pos - 3'd1;
                        end
                    end
                end
            end
            cae_pkg::S_DIV: begin
                // magnitude over ten through the reciprocal
                n_acc   = A'(w_prod[2*W:W+3]);
                n_state = cae_pkg::S_BFIN;
            end
            cae_pkg::S_BFIN: begin
                if (r_turn) begin
                    n_line = w_bres;
                end else begin
                    n_col = w_bres;
                end
                if (r_end) begin
                    n_emit_b  = 8'h00;
                    n_emit_bv = 1'b0;
                    n_state   = cae_pkg::S_EMIT;
                end else begin
                    n_state = cae_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cae_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cae_pkg::S_IDLE;
            r_phase <= cae_pkg::PH_TEXT;
            r_thr   <= '0;
            r_line  <= '0;
            r_col   <= '0;
            r_turn  <= 1'b1;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_thr   <= n_thr;
            r_line  <= n_line;
            r_col   <= n_col;
            r_turn  <= n_turn;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_end     <= n_end;
        r_emit_b  <= n_emit_b;
        r_emit_bv <= n_emit_bv;
        r_acc     <= n_acc;
        r_digit   <= n_digit;
        r_pos     <= n_pos;
        r_pad     <= n_pad;
        r_started <= n_started;
        r_neg     <= n_neg;
    end

    cae_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_stall (i_out_stall)
    );

    assign o_out_byte      = w_out.out_byte;
    assign o_byte_valid    = w_out.byte_valid;
    assign o_bad_template  = w_out.bad_template;
    assign o_end_of_string = w_out.end_of_string;

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == cae_pkg::S_EXEC))
        else $error("accepted request not decoded next cycle");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cae_pkg::S_DEC) |-> (r_digit <= 4'd9))
        else $error("decimal digit above nine");

    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_template) |-> (!o_byte_valid && o_out_byte == 8'h00))
        else $error("character sent with error flag set");
`endif

endmodule
`default_nettype wire
